@@ rtl/core/timer_min_heap_queue_unit_assert.svh @@
// Assertion macros for the timer heap queue.
// Used by timer_min_heap_queue_unit.sv; expects clk and rst_n in scope.
`ifndef TIMER_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define TIMER_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define TMHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tmhq_pkg.sv @@
// Shared types and constants of the timer heap queue.
// No dependencies; used by timer_min_heap_queue_unit.
package tmhq_pkg;

  localparam int DEF_TIMER_SLOTS = 64;
  localparam int DEF_TIME_BITS   = 48;
  localparam int RESULT_CAP      = 64;
  localparam int US_PER_MS       = 1000;
  localparam int CMD_W           = 3;
  localparam int ID_W            = 6;
  localparam int WAIT_W          = 32;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PROC  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHIFT = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [WAIT_W-1:0] WAIT_NONE = '1;

  typedef struct packed {
    logic [1:0]        status;
    logic              fired;
    logic [ID_W-1:0]   expired_id;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } res_t;

  function automatic res_t mk_res(input logic [1:0] st, input logic fi,
                                  input logic [ID_W-1:0] id,
                                  input logic [WAIT_W-1:0] wt, input logic la);
    res_t r;
    r.status     = st;
    r.fired      = fi;
    r.expired_id = id;
    r.wait_ms    = wt;
    r.last       = la;
    return r;
  endfunction

endpackage

@@ rtl/core/timer_min_heap_queue_unit.sv @@
// Timer queue held as a binary min-heap of timer ids, keyed by deadline.
// Depends on tmhq_pkg and timer_min_heap_queue_unit_assert.svh.
//
// Usage: commands arrive on the in_ channel (valid/stall). An item is taken
// only while the unit is idle; in_stall is high for the whole of a command.
// Add, delete, query and shift give one result item each; process gives one
// result item per expired timer (at most 64), the final one carrying last,
// or a single item with fired low when nothing has expired.
// Add walks the heap up one level at a time (S_UP, S_UPCMP); delete first
// reads the timer's heap slot (S_DELPOS), then erases it (S_ER0, S_ER1).
// Each popped timer in a process costs an erase walk plus, for a repeating
// timer, an insert walk. Query divides by 1000 as a drop of three bits and a
// multiply by a reciprocal of 125 in 16-bit steps, one step per cycle.
// Shift-back reads and rewrites each armed timer in turn through the single
// heap write port. The heap memory has one write and two read ports.
// Reset empties the heap and disarms every id at once; no clearing pass.
// Results sit in an output register; while out_stall is high the unit
// holds that item and waits before producing the next one.
module timer_min_heap_queue_unit #(
  parameter int TIMER_SLOTS = tmhq_pkg::DEF_TIMER_SLOTS,
  parameter int TIME_BITS   = tmhq_pkg::DEF_TIME_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tmhq_pkg::CMD_W-1:0] in_command,
  input  logic [tmhq_pkg::ID_W-1:0]  in_timer_id,
  input  logic [TIME_BITS-1:0]       in_delay_us,
  input  logic                       in_repeat_req,
  input  logic [TIME_BITS-1:0]       in_now_us,
  input  logic [TIME_BITS-1:0]       in_shift_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic                       out_fired,
  output logic [tmhq_pkg::ID_W-1:0]  out_expired_id,
  output logic [tmhq_pkg::WAIT_W-1:0] out_wait_ms,
  output logic                       out_last
);

  localparam int TB  = TIME_BITS;
  localparam int IDW = $clog2(TIMER_SLOTS);
  localparam int CW  = $clog2(TIMER_SLOTS + 1);
  localparam int CW2 = IDW + 2;
  localparam int NW  = $clog2(tmhq_pkg::RESULT_CAP + 1);

  // Division by 1000 is a drop of three bits and a multiply by the rounded-up
  // reciprocal of 125, exact for every dividend below 2^(TB-3).
  localparam int QN  = TB - 3;
  localparam int RK  = QN + 7;
  localparam int MW  = TB - 2;
  localparam int MCH = (MW + 15) / 16;
  localparam int RW  = 16 * MCH;
  localparam int PW  = QN + RW;
  localparam int MPW = QN + 16;
  localparam int DCW = $clog2(MCH + 1);
  localparam logic [RW-1:0] RECIP = RW'(((129'd1 << RK) + 129'd124) / 129'd125);

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_DELPOS = 5'd2;
  localparam logic [4:0] S_ER0    = 5'd3;
  localparam logic [4:0] S_ER1    = 5'd4;
  localparam logic [4:0] S_UP     = 5'd5;
  localparam logic [4:0] S_UPCMP  = 5'd6;
  localparam logic [4:0] S_DN     = 5'd7;
  localparam logic [4:0] S_DNCMP  = 5'd8;
  localparam logic [4:0] S_SDONE  = 5'd9;
  localparam logic [4:0] S_PR     = 5'd10;
  localparam logic [4:0] S_PRTOP  = 5'd11;
  localparam logic [4:0] S_FIN    = 5'd12;
  localparam logic [4:0] S_QTOP   = 5'd13;
  localparam logic [4:0] S_DIV    = 5'd14;
  localparam logic [4:0] S_SH     = 5'd15;
  localparam logic [4:0] S_SHWR   = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                            input logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? {TB{1'b1}} : s[TB-1:0];
  endfunction

  // Heap storage by slot, timer data by id.
  logic [IDW-1:0] hid_mem  [TIMER_SLOTS];
  logic [TB-1:0]  hkey_mem [TIMER_SLOTS];
  logic [IDW-1:0] pos_mem  [TIMER_SLOTS];
  logic [TB-1:0]  per_mem  [TIMER_SLOTS];
  logic           rep_mem  [TIMER_SLOTS];

  logic [IDW-1:0] ha_id_r, hb_id_r;
  logic [TB-1:0]  ha_key_r, hb_key_r;
  logic [IDW-1:0] pos_q_r;
  logic [TB-1:0]  per_q_r;
  logic           rep_q_r;

  // Latched command.
  logic [tmhq_pkg::CMD_W-1:0] cmd_r;
  logic [tmhq_pkg::ID_W-1:0]  tid_r;
  logic [TB-1:0]              delay_r, now_r, shift_r;
  logic                       rep_req_r;

  // Control state.
  logic [4:0]       state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IDW-1:0]   hole_r, hole_nxt;
  logic [IDW-1:0]   cur_id_r, cur_id_nxt, top_r, top_nxt;
  logic [TB-1:0]    cur_key_r, cur_key_nxt;
  logic             readd_r, readd_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IDW-1:0]   pend_id_r, pend_id_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [TIMER_SLOTS-1:0] armed_r, armed_nxt;
  logic [TB-1:0]    dv_r, dv_nxt;
  logic [PW-1:0]    acc_r, acc_nxt;
  logic [RW-1:0]    rc_r, rc_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  logic [CW-1:0]    sh_i_r, sh_i_nxt;
  tmhq_pkg::res_t   res_r, res_nxt, out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Memory port controls.
  logic [IDW-1:0] ha_addr, hb_addr;
  logic           hwe;
  logic [IDW-1:0] hwa, hwd_id;
  logic [TB-1:0]  hwd_key;
  logic           pwe;
  logic [IDW-1:0] pwa, pwd;
  logic           perwe, per_re;

  logic                in_acc;
  logic [IDW-1:0]      tid_idx, par_idx, sel_id, sel_idx;
  logic                tid_ok, useb;
  logic [CW2-1:0]      c_pos, cnt2;
  logic [TB-1:0]       sel_key, per_eff;
  logic [MPW-1:0]      mprod;
  logic [63:0]         q64;
  logic [tmhq_pkg::WAIT_W-1:0] wait_v;

  assign in_acc  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign tid_idx = IDW'(tid_r);
  assign tid_ok  = (32'(tid_r) < 32'(TIMER_SLOTS));
  assign par_idx = IDW'((hole_r - IDW'(1)) >> 1);
  assign c_pos   = CW2'({hole_r, 1'b0}) + CW2'(2);
  assign cnt2    = CW2'(count_r);
  assign useb    = (c_pos == cnt2) || (ha_key_r > hb_key_r);
  assign sel_id  = useb ? hb_id_r : ha_id_r;
  assign sel_key = useb ? hb_key_r : ha_key_r;
  assign sel_idx = useb ? IDW'(c_pos - CW2'(1)) : IDW'(c_pos);
  assign per_eff = (per_q_r == '0) ? TB'(1) : per_q_r;
  assign mprod   = MPW'(dv_r[TB-1:3]) * MPW'(rc_r[RW-1 -: 16]);
  assign q64     = 64'(acc_r[PW-1:RK]);
  assign wait_v  = (|q64[63:32]) ? tmhq_pkg::WAIT_NONE : q64[31:0];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    count_nxt     = count_r;
    hole_nxt      = hole_r;
    cur_id_nxt    = cur_id_r;
    cur_key_nxt   = cur_key_r;
    top_nxt       = top_r;
    readd_nxt     = readd_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    n_nxt         = n_r;
    armed_nxt     = armed_r;
    dv_nxt        = dv_r;
    acc_nxt       = acc_r;
    rc_nxt        = rc_r;
    dcnt_nxt      = dcnt_r;
    sh_i_nxt      = sh_i_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ha_addr       = '0;
    hb_addr       = '0;
    hwe           = 1'b0;
    hwa           = hole_r;
    hwd_id        = cur_id_r;
    hwd_key       = cur_key_r;
    pwe           = 1'b0;
    pwa           = cur_id_r;
    pwd           = hole_r;
    perwe         = 1'b0;
    per_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt  = S_DISP;
          pend_v_nxt = 1'b0;
          n_nxt      = '0;
          readd_nxt  = 1'b0;
        end
      end
      S_DISP: begin
        ret_nxt = S_IDLE;
        unique case (cmd_r)
          tmhq_pkg::CMD_ADD: begin
            if (!tid_ok || armed_r[tid_idx]) begin
              res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_BAD, 1'b0, '0, '0, 1'b1);
              state_nxt = S_EMIT;
            end else if (count_r == CW'(TIMER_SLOTS)) begin
              res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_FULL, 1'b0, '0, '0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              perwe              = 1'b1;
              cur_id_nxt         = tid_idx;
              cur_key_nxt        = sat_add(now_r, delay_r);
              hole_nxt           = IDW'(count_r);
              count_nxt          = count_r + CW'(1);
              armed_nxt[tid_idx] = 1'b1;
              state_nxt          = S_UP;
            end
          end
          tmhq_pkg::CMD_DEL: begin
            if (!tid_ok || !armed_r[tid_idx]) begin
              res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_BAD, 1'b0, '0, '0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              armed_nxt[tid_idx] = 1'b0;
              state_nxt          = S_DELPOS;
            end
          end
          tmhq_pkg::CMD_PROC: begin
            state_nxt = S_PR;
          end
          tmhq_pkg::CMD_QUERY: begin
            if (count_r == '0) begin
              res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b0, '0,
                                           tmhq_pkg::WAIT_NONE, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_QTOP;
            end
          end
          tmhq_pkg::CMD_SHIFT: begin
            sh_i_nxt  = '0;
            state_nxt = S_SH;
          end
          default: begin
            res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_BAD, 1'b0, '0, '0, 1'b1);
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_DELPOS: begin
        hole_nxt  = pos_q_r;
        state_nxt = S_ER0;
      end
      S_ER0: begin
        count_nxt = count_r - CW'(1);
        ha_addr   = IDW'(count_r - CW'(1));
        hb_addr   = par_idx;
        state_nxt = S_ER1;
      end
      S_ER1: begin
        cur_id_nxt  = ha_id_r;
        cur_key_nxt = ha_key_r;
        if (hole_r != '0 && hb_key_r > ha_key_r) begin
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_UP: begin
        if (hole_r == '0) begin
          hwe       = 1'b1;
          pwe       = 1'b1;
          state_nxt = S_SDONE;
        end else begin
          ha_addr   = par_idx;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        hwe = 1'b1;
        pwe = 1'b1;
        if (ha_key_r > cur_key_r) begin
          hwd_id    = ha_id_r;
          hwd_key   = ha_key_r;
          pwa       = ha_id_r;
          hole_nxt  = par_idx;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_SDONE;
        end
      end
      S_DN: begin
        if (c_pos > cnt2) begin
          hwe       = 1'b1;
          pwe       = 1'b1;
          state_nxt = S_SDONE;
        end else begin
          ha_addr   = (c_pos < cnt2) ? IDW'(c_pos) : IDW'(c_pos - CW2'(1));
          hb_addr   = IDW'(c_pos - CW2'(1));
          state_nxt = S_DNCMP;
        end
      end
      S_DNCMP: begin
        hwe = 1'b1;
        pwe = 1'b1;
        if (cur_key_r > sel_key) begin
          hwd_id    = sel_id;
          hwd_key   = sel_key;
          pwa       = sel_id;
          hole_nxt  = sel_idx;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_SDONE;
        end
      end
      S_SDONE: begin
        if (cmd_r == tmhq_pkg::CMD_PROC) begin
          if (!readd_r && rep_q_r) begin
            readd_nxt        = 1'b1;
            cur_id_nxt       = top_r;
            cur_key_nxt      = sat_add(now_r, per_eff);
            hole_nxt         = IDW'(count_r);
            count_nxt        = count_r + CW'(1);
            armed_nxt[top_r] = 1'b1;
            state_nxt        = S_UP;
          end else begin
            readd_nxt   = 1'b0;
            pend_v_nxt  = 1'b1;
            pend_id_nxt = top_r;
            n_nxt       = n_r + NW'(1);
            if (pend_v_r) begin
              res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b1,
                                           tmhq_pkg::ID_W'(pend_id_r), '0, 1'b0);
              ret_nxt   = S_PR;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_PR;
            end
          end
        end else begin
          res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end
      end
      S_PR: begin
        if (count_r == '0 || n_r == NW'(tmhq_pkg::RESULT_CAP)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PRTOP;
        end
      end
      S_PRTOP: begin
        if (ha_key_r > now_r) begin
          state_nxt = S_FIN;
        end else begin
          top_nxt            = ha_id_r;
          armed_nxt[ha_id_r] = 1'b0;
          hole_nxt           = '0;
          per_re             = 1'b1;
          state_nxt          = S_ER0;
        end
      end
      S_FIN: begin
        res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, pend_v_r,
                                     pend_v_r ? tmhq_pkg::ID_W'(pend_id_r) : '0,
                                     '0, 1'b1);
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
      end
      S_QTOP: begin
        if (ha_key_r <= now_r) begin
          res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          dv_nxt    = ha_key_r - now_r;
          acc_nxt   = '0;
          rc_nxt    = RECIP;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // Reciprocal product built up 16 bits of the constant at a time,
        // most significant part first.
        if (dcnt_r == DCW'(MCH)) begin
          res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b0, '0, wait_v, 1'b1);
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          acc_nxt  = {acc_r[PW-17:0], 16'd0} + PW'(mprod);
          rc_nxt   = {rc_r[RW-17:0], 16'd0};
          dcnt_nxt = dcnt_r + DCW'(1);
        end
      end
      S_SH: begin
        if (sh_i_r == count_r) begin
          res_nxt   = tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          ha_addr   = IDW'(sh_i_r);
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        hwe       = 1'b1;
        hwa       = IDW'(sh_i_r);
        hwd_id    = ha_id_r;
        hwd_key   = (ha_key_r > shift_r) ? ha_key_r - shift_r : '0;
        sh_i_nxt  = sh_i_r + CW'(1);
        state_nxt = S_SH;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_PR) begin
      ha_addr = '0;
    end
  end

  // Heap and per-id memories, registered reads.
  always_ff @(posedge clk) begin
    if (hwe) begin
      hid_mem[hwa]  <= hwd_id;
      hkey_mem[hwa] <= hwd_key;
    end
    ha_id_r  <= hid_mem[ha_addr];
    ha_key_r <= hkey_mem[ha_addr];
    hb_id_r  <= hid_mem[hb_addr];
    hb_key_r <= hkey_mem[hb_addr];
    if (pwe) begin
      pos_mem[pwa] <= pwd;
    end
    pos_q_r <= pos_mem[tid_idx];
    if (perwe) begin
      per_mem[tid_idx] <= delay_r;
      rep_mem[tid_idx] <= rep_req_r;
    end
    if (per_re) begin
      per_q_r <= per_mem[ha_id_r];
      rep_q_r <= rep_mem[ha_id_r];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_command;
      tid_r     <= in_timer_id;
      delay_r   <= in_delay_us;
      rep_req_r <= in_repeat_req;
      now_r     <= in_now_us;
      shift_r   <= in_shift_us;
    end
    ret_r     <= ret_nxt;
    hole_r    <= hole_nxt;
    cur_id_r  <= cur_id_nxt;
    cur_key_r <= cur_key_nxt;
    top_r     <= top_nxt;
    pend_id_r <= pend_id_nxt;
    dv_r      <= dv_nxt;
    acc_r     <= acc_nxt;
    rc_r      <= rc_nxt;
    dcnt_r    <= dcnt_nxt;
    sh_i_r    <= sh_i_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      armed_r     <= '0;
      readd_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      armed_r     <= armed_nxt;
      readd_r     <= readd_nxt;
      pend_v_r    <= pend_v_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_fired      = out_r.fired;
  assign out_expired_id = out_r.expired_id;
  assign out_wait_ms    = out_r.wait_ms;
  assign out_last       = out_r.last;

`include "timer_min_heap_queue_unit_assert.svh"

  `TMHQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(TIMER_SLOTS), "heap count over capacity")
  `TMHQ_ASSERT_NXT(a_busy_after_accept, in_acc, state_r != S_IDLE, "idle after taking an item")
  `TMHQ_ASSERT_NXT(a_count_step, 1'b1, (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)), "heap count jumped")

endmodule

@@ verif/tmhq_checker.sv @@
// Checker for the timer heap queue: keeps its own copy of the heap and
// compares every result item against the predicted one.
// Depends on tmhq_pkg for result types and command and status codes.
`timescale 1ns / 1ps

module tmhq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_timer_id,
  input  logic [47:0] in_delay_us,
  input  logic        in_repeat_req,
  input  logic [47:0] in_now_us,
  input  logic [47:0] in_shift_us,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        out_fired,
  input  logic [5:0]  out_expired_id,
  input  logic [31:0] out_wait_ms,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  localparam int SLOTS = 64;
  localparam logic [47:0] TMAX = '1;

  logic [5:0]  slot_id  [SLOTS];
  logic [47:0] due_us   [SLOTS];
  logic [47:0] period_us[SLOTS];
  logic        rearm    [SLOTS];
  int          slot_of  [SLOTS];
  int          armed_cnt;

  tmhq_pkg::res_t expected_results[$];

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TMAX : s[47:0];
  endfunction

  // Single closing item with the given status and nothing else set.
  function automatic tmhq_pkg::res_t plain_res(input logic [1:0] st);
    return tmhq_pkg::mk_res(st, 1'b0, '0, '0, 1'b1);
  endfunction

  function automatic void heap_up(int hole, logic [5:0] id);
    int p;
    while (hole > 0) begin
      p = (hole - 1) / 2;
      if (!(due_us[slot_id[p]] > due_us[id])) break;
      slot_id[hole] = slot_id[p];
      slot_of[slot_id[hole]] = hole;
      hole = p;
    end
    slot_id[hole] = id;
    slot_of[id] = hole;
  endfunction

  function automatic void heap_down(int hole, logic [5:0] id);
    int c;
    c = 2 * hole + 2;
    while (c <= armed_cnt) begin
      // Ties go to the right child; the left is taken only if strictly earlier.
      if (c == armed_cnt) c--;
      else if (due_us[slot_id[c]] > due_us[slot_id[c-1]]) c--;
      if (!(due_us[id] > due_us[slot_id[c]])) break;
      slot_id[hole] = slot_id[c];
      slot_of[slot_id[hole]] = hole;
      hole = c;
      c = 2 * hole + 2;
    end
    slot_id[hole] = id;
    slot_of[id] = hole;
  endfunction

  function automatic void heap_remove(logic [5:0] id);
    int p;
    logic [5:0] tail;
    p = slot_of[id];
    armed_cnt--;
    tail = slot_id[armed_cnt];
    if (p > 0 && due_us[slot_id[(p-1)/2]] > due_us[tail]) heap_up(p, tail);
    else heap_down(p, tail);
    slot_of[id] = -1;
  endfunction

  function automatic void predict_timers(logic [2:0] cmd, logic [5:0] id, logic [47:0] dly,
                                         logic rep, logic [47:0] now, logic [47:0] sh);
    int n;
    logic [5:0] top;
    logic [47:0] per;
    logic [47:0] d;
    logic [47:0] w;
    case (cmd)
      tmhq_pkg::CMD_ADD: begin
        if (slot_of[id] != -1) expected_results.push_back(plain_res(tmhq_pkg::ST_BAD));
        else if (armed_cnt >= SLOTS) expected_results.push_back(plain_res(tmhq_pkg::ST_FULL));
        else begin
          period_us[id] = dly;
          rearm[id] = rep;
          due_us[id] = add_sat(now, dly);
          heap_up(armed_cnt, id);
          armed_cnt++;
          expected_results.push_back(plain_res(tmhq_pkg::ST_OK));
        end
      end
      tmhq_pkg::CMD_DEL: begin
        if (slot_of[id] == -1) expected_results.push_back(plain_res(tmhq_pkg::ST_BAD));
        else begin
          heap_remove(id);
          expected_results.push_back(plain_res(tmhq_pkg::ST_OK));
        end
      end
      tmhq_pkg::CMD_PROC: begin
        n = 0;
        while (armed_cnt > 0 && n < tmhq_pkg::RESULT_CAP) begin
          top = slot_id[0];
          if (due_us[top] > now) break;
          heap_remove(top);
          if (rearm[top]) begin
            per = (period_us[top] == '0) ? 48'd1 : period_us[top];
            due_us[top] = add_sat(now, per);
            heap_up(armed_cnt, top);
            armed_cnt++;
          end
          expected_results.push_back(tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b1, top, '0,
                                                       1'b0));
          n++;
        end
        if (n == 0) expected_results.push_back(plain_res(tmhq_pkg::ST_OK));
        else expected_results[$].last = 1'b1;
      end
      tmhq_pkg::CMD_QUERY: begin
        if (armed_cnt == 0) w = {16'd0, tmhq_pkg::WAIT_NONE};
        else begin
          d = due_us[slot_id[0]];
          if (d <= now) w = '0;
          else begin
            w = (d - now) / 48'(tmhq_pkg::US_PER_MS);
            if (w > {16'd0, tmhq_pkg::WAIT_NONE}) w = {16'd0, tmhq_pkg::WAIT_NONE};
          end
        end
        expected_results.push_back(tmhq_pkg::mk_res(tmhq_pkg::ST_OK, 1'b0, '0, w[31:0],
                                                     1'b1));
      end
      tmhq_pkg::CMD_SHIFT: begin
        for (int i = 0; i < armed_cnt; i++) begin
          d = due_us[slot_id[i]];
          due_us[slot_id[i]] = (d > sh) ? d - sh : 48'd0;
        end
        expected_results.push_back(plain_res(tmhq_pkg::ST_OK));
      end
      default: expected_results.push_back(plain_res(tmhq_pkg::ST_BAD));
    endcase
  endfunction

  tmhq_pkg::res_t seen;
  tmhq_pkg::res_t want;

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      armed_cnt = 0;
      fail_count <= 0;
      for (int i = 0; i < SLOTS; i++) slot_of[i] = -1;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_timers(in_command, in_timer_id, in_delay_us, in_repeat_req, in_now_us,
                       in_shift_us);
      if (out_valid && !out_stall) begin
        seen = tmhq_pkg::mk_res(out_status, out_fired, out_expired_id, out_wait_ms, out_last);
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result item: %p", seen);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status || seen.fired !== want.fired ||
              seen.expired_id !== want.expired_id || seen.wait_ms !== want.wait_ms ||
              seen.last !== want.last) begin
            if (fail_count < 10) $display("Mismatch: expected %p, got %p", want, seen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/testbench.sv @@
// Top of the timer heap queue bench: clock, reset, command stimulus and verdict.
// Depends on tmhq_pkg, timer_min_heap_queue_unit and tmhq_checker.
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [5:0]  in_timer_id = '0;
  logic [47:0] in_delay_us = '0;
  logic        in_repeat_req = 1'b0;
  logic [47:0] in_now_us = '0;
  logic [47:0] in_shift_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_fired;
  logic [5:0]  out_expired_id;
  logic [31:0] out_wait_ms;
  logic        out_last;
  int          fail_count;
  int          pending;

  // When set, neither side idles, so back-to-back items get exercised too.
  bit          no_gaps = 1'b0;
  int          stall_left = 0;
  logic [47:0] clock_us = '0;

  always #5 clk = ~clk;

  timer_min_heap_queue_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_timer_id(in_timer_id), .in_delay_us(in_delay_us), .in_repeat_req(in_repeat_req),
    .in_now_us(in_now_us), .in_shift_us(in_shift_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_fired(out_fired), .out_expired_id(out_expired_id), .out_wait_ms(out_wait_ms),
    .out_last(out_last)
  );

  tmhq_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_timer_id(in_timer_id), .in_delay_us(in_delay_us), .in_repeat_req(in_repeat_req),
    .in_now_us(in_now_us), .in_shift_us(in_shift_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_fired(out_fired), .out_expired_id(out_expired_id), .out_wait_ms(out_wait_ms),
    .out_last(out_last), .fail_count(fail_count), .pending(pending)
  );

  // Gap lengths are mostly zero or short, with the occasional long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls in runs whose length follows the same shape.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // Offers one item and holds it until the unit takes it. The valid is only
  // lowered when a gap follows, so it is never dropped and raised in one step.
  task automatic send_cmd(logic [2:0] cmd, logic [5:0] id, logic [47:0] dly, logic rep,
                          logic [47:0] now, logic [47:0] sh);
    int g;
    in_command <= cmd;
    in_timer_id <= id;
    in_delay_us <= dly;
    in_repeat_req <= rep;
    in_now_us <= now;
    in_shift_us <= sh;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Random 48-bit value that sets every bit both ways over the run.
  function automatic logic [47:0] any_time();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int r;
    int wait_cycles;
    logic [2:0]  cmd;
    logic [47:0] dly;
    logic [47:0] sh;
    logic [47:0] now;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty heap answers all ones, and process on it fires nothing.
    send_cmd(tmhq_pkg::CMD_QUERY, 6'd0, 48'd0, 1'b0, 48'd0, 48'd0);
    send_cmd(tmhq_pkg::CMD_PROC, 6'd0, 48'd0, 1'b0, 48'd0, 48'd0);
    // Deleting an idle id and re-adding an armed one both answer bad status.
    send_cmd(tmhq_pkg::CMD_DEL, 6'd5, 48'd0, 1'b0, 48'd0, 48'd0);
    send_cmd(tmhq_pkg::CMD_ADD, 6'd0, 48'd0, 1'b1, 48'd0, 48'd0);
    send_cmd(tmhq_pkg::CMD_ADD, 6'd0, 48'd7, 1'b0, 48'd0, 48'd0);
    // Deadline addition saturates; the far wait then saturates at all ones.
    send_cmd(tmhq_pkg::CMD_ADD, 6'd63, '1, 1'b0, '1, 48'd0);
    send_cmd(tmhq_pkg::CMD_DEL, 6'd0, 48'd0, 1'b0, 48'd0, 48'd0);
    send_cmd(tmhq_pkg::CMD_QUERY, 6'd0, 48'd0, 1'b0, 48'd0, 48'd0);
    send_cmd(tmhq_pkg::CMD_QUERY, 6'd0, 48'd0, 1'b0, '1, 48'd0);
    // A shift larger than every deadline clamps them all at zero.
    send_cmd(tmhq_pkg::CMD_SHIFT, 6'd0, 48'd0, 1'b0, 48'd0, '1);
    send_cmd(tmhq_pkg::CMD_QUERY, 6'd0, 48'd0, 1'b0, 48'd5, 48'd0);
    send_cmd(3'd5, 6'd1, 48'd0, 1'b0, 48'd0, 48'd0);
    send_cmd(3'd6, 6'd2, 48'd0, 1'b0, 48'd0, 48'd0);
    send_cmd(3'd7, 6'd3, 48'd0, 1'b0, 48'd0, 48'd0);
    // Zero-period repeating timer comes back one microsecond after expiry.
    send_cmd(tmhq_pkg::CMD_PROC, 6'd0, 48'd0, 1'b0, 48'd100, 48'd0);
    send_cmd(tmhq_pkg::CMD_ADD, 6'd10, 48'd0, 1'b1, 48'd100, 48'd0);
    send_cmd(tmhq_pkg::CMD_PROC, 6'd0, 48'd0, 1'b0, 48'd100, 48'd0);
    send_cmd(tmhq_pkg::CMD_QUERY, 6'd0, 48'd0, 1'b0, 48'd100, 48'd0);
    send_cmd(tmhq_pkg::CMD_DEL, 6'd10, 48'd0, 1'b0, 48'd0, 48'd0);

    // Fill every slot with equal and near deadlines so ties and the cap on
    // expiries per process command are both reached.
    for (int i = 0; i < 64; i++)
      send_cmd(tmhq_pkg::CMD_ADD, i[5:0], 48'($urandom_range(0, 3)), i[0], 48'd1000, 48'd0);
    send_cmd(tmhq_pkg::CMD_PROC, 6'd0, 48'd0, 1'b0, 48'd5000, 48'd0);
    send_cmd(tmhq_pkg::CMD_PROC, 6'd0, 48'd0, 1'b0, 48'd6000, 48'd0);
    for (int i = 0; i < 64; i++)
      send_cmd(tmhq_pkg::CMD_DEL, i[5:0], 48'd0, 1'b0, 48'd0, 48'd0);

    // Random part: mostly adds, deletes and processes on an advancing clock.
    clock_us = 48'd10000;
    for (int k = 0; k < 30; k++) begin
      if (k % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) cmd = tmhq_pkg::CMD_ADD;
      else if (r < 55) cmd = tmhq_pkg::CMD_DEL;
      else if (r < 75) cmd = tmhq_pkg::CMD_PROC;
      else if (r < 88) cmd = tmhq_pkg::CMD_QUERY;
      else if (r < 95) cmd = tmhq_pkg::CMD_SHIFT;
      else cmd = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 9);
      dly = (r < 7) ? 48'($urandom_range(0, 200000)) : (r < 9) ? any_time() : '1;
      sh = ($urandom_range(0, 4) == 0) ? any_time() : 48'($urandom_range(0, 50000));
      clock_us = clock_us + 48'($urandom_range(0, 60000));
      now = ($urandom_range(0, 19) == 0) ? any_time() : clock_us;
      send_cmd(cmd, 6'($urandom_range(0, 63)), dly, 1'($urandom_range(0, 1)), now, sh);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // Let any stray item surface before the verdict.
    wait_cycles = 200;
    repeat (wait_cycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tmhq_pkg.sv
rtl/core/timer_min_heap_queue_unit.sv
verif/tmhq_checker.sv
verif/testbench.sv
